// ===== rtl/core/ats_pkg.sv =====
package ats_pkg;

    localparam int TIME_W     = 32;
    localparam int FREQ_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DLT_W      = TIME_W + 1;
    localparam int PROD_W     = DLT_W + FREQ_W;
    localparam int FRAC_SHIFT = 8;
    localparam int T_W        = 36;
    localparam int REM_W      = 34;
    localparam int REM_CNT_W  = $clog2(REM_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_START      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_STOP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_BACKWARDS = 3'd5;

    localparam logic [MODE_W-1:0] MODE_LOOP    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLAMP   = 2'd2;

    localparam logic [TIME_W-1:0] KEY_START_UNSET = 32'h7FFF_FFFF;
    localparam logic [TIME_W-1:0] KEY_STOP_UNSET  = 32'h8000_0000;
    localparam logic [TIME_W-1:0] TIME_MAX        = 32'h7FFF_FFFF;
    localparam logic [TIME_W-1:0] TIME_MIN        = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_WRAP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_sts;

endpackage

// ===== rtl/core/ats_rem.sv =====
module ats_rem
    import ats_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REM_W-1:0] i_dividend,
    input  logic [REM_W-1:0] i_divisor,
    output t_rem_sts         o_sts,
    output logic [REM_W-1:0] o_rem
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [REM_CNT_W-1:0] r_cnt, n_cnt;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [REM_W-1:0]     r_dvd, n_dvd;
    logic [REM_W-1:0]     r_dsr, n_dsr;
    logic [REM_W:0]       w_trial;
    logic [REM_W:0]       w_diff;

    // one restoring step per cycle, MSB of dividend first
    assign w_trial = {r_rem, r_dvd[REM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = REM_CNT_W'(REM_W);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_diff[REM_W] ? w_trial[REM_W-1:0] : w_diff[REM_W-1:0];
            n_dvd = {r_dvd[REM_W-2:0], 1'b0};
            n_cnt = r_cnt - REM_CNT_W'(1);
            if (r_cnt == REM_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_rem      = r_rem;

endmodule

// ===== rtl/core/animation_time_scaler.sv =====
// Each input transfer runs through the states MUL, ACC and WRAP, then DIV, waiting on the
// shared serial remainder unit, when the loop or reverse wrap runs, and last DONE.
// Input stalls while an item is in work, the result register lets the next item start
// while a result waits.
// Reset (i_rst_n, synchronous, active low) resets configuration, history and output valid.
module animation_time_scaler
    import ats_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [TIME_W-1:0]     i_global_time,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TIME_W-1:0]     o_scaled_time,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    function automatic logic signed [T_W-1:0] sx(input logic [TIME_W-1:0] v);
        return {{(T_W-TIME_W){v[TIME_W-1]}}, v};
    endfunction

    logic [FREQ_W-1:0] r_freq;
    logic [TIME_W-1:0] r_phase;
    logic [TIME_W-1:0] r_key_start;
    logic [TIME_W-1:0] r_key_stop;
    logic [MODE_W-1:0] r_cycle_mode;
    logic              r_play_back;

    t_state                    r_state, n_state;
    logic                      r_have, n_have;
    logic [TIME_W-1:0]         r_prev, n_prev;
    logic [TIME_W-1:0]         r_we, n_we;
    logic signed [DLT_W-1:0]   r_delta, n_delta;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [T_W-1:0]     r_t, n_t;
    logic                      r_x_neg, n_x_neg;
    logic [TIME_W-1:0]         r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic                      w_in_xfer;
    logic                      w_out_xfer;
    logic                      w_start;
    t_rem_sts                  w_rem_sts;
    logic [REM_W-1:0]          w_rem;

    logic signed [PROD_W:0]    w_sum;
    logic signed [PROD_W-1:0]  w_prod_sh;
    logic [TIME_W-1:0]         w_we_sat;
    logic signed [T_W-1:0]     w_kst, w_ksp, w_span, w_dspan, w_t, w_x, w_x_mag;
    logic signed [T_W-1:0]     w_d, w_d_mag, w_r, w_f, w_t_loop, w_t_rev;
    logic signed [T_W-1:0]     w_clamp, w_back;
    logic                      w_keys_set, w_wrap_mode;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq       <= '0;
            r_phase      <= '0;
            r_key_start  <= KEY_START_UNSET;
            r_key_stop   <= KEY_STOP_UNSET;
            r_cycle_mode <= MODE_CLAMP;
            r_play_back  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FREQUENCY:      r_freq       <= i_cfg_data[FREQ_W-1:0];
                REG_PHASE:          r_phase      <= i_cfg_data[TIME_W-1:0];
                REG_KEY_START:      r_key_start  <= i_cfg_data[TIME_W-1:0];
                REG_KEY_STOP:       r_key_stop   <= i_cfg_data[TIME_W-1:0];
                REG_CYCLE_MODE:     r_cycle_mode <= i_cfg_data[MODE_W-1:0];
                REG_PLAY_BACKWARDS: r_play_back  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // accumulate: floor(delta * freq / 256), saturate to 32 bits
    assign w_prod_sh = r_prod >>> FRAC_SHIFT;
    assign w_sum     = $signed({{(PROD_W+1-TIME_W){r_we[TIME_W-1]}}, r_we})
                     + $signed({w_prod_sh[PROD_W-1], w_prod_sh});
    always_comb begin
        if (&w_sum[PROD_W:TIME_W-1] || ~|w_sum[PROD_W:TIME_W-1]) begin
            w_we_sat = w_sum[TIME_W-1:0];
        end else begin
            w_we_sat = w_sum[PROD_W] ? TIME_MIN : TIME_MAX;
        end
    end

    assign w_kst       = sx(r_key_start);
    assign w_ksp       = sx(r_key_stop);
    assign w_span      = w_ksp - w_kst;
    assign w_dspan     = w_span <<< 1;
    assign w_t         = sx(r_we) + sx(r_phase);
    assign w_x         = w_t - w_kst;
    assign w_x_mag     = w_x[T_W-1] ? -w_x : w_x;
    assign w_d         = (r_cycle_mode == MODE_LOOP) ? w_span : w_dspan;
    assign w_d_mag     = w_d[T_W-1] ? -w_d : w_d;
    assign w_keys_set  = (r_key_start != KEY_START_UNSET) && (r_key_stop != KEY_STOP_UNSET);
    assign w_wrap_mode = r_cycle_mode inside {MODE_LOOP, MODE_REVERSE};

    // truncating remainder takes the dividend's sign
    assign w_r      = r_x_neg ? -$signed({{(T_W-REM_W){1'b0}}, w_rem})
                              : $signed({{(T_W-REM_W){1'b0}}, w_rem});
    assign w_t_loop = w_r + w_kst + (w_r[T_W-1] ? w_span : '0);
    assign w_f      = w_r[T_W-1] ? (w_r + w_dspan) : w_r;
    assign w_t_rev  = (w_f > w_span) ? (w_dspan - w_f + w_kst) : (w_f + w_kst);

    assign w_clamp  = (r_t > w_ksp) ? w_ksp : ((r_t < w_kst) ? w_kst : r_t);
    assign w_back   = w_ksp - w_clamp + w_kst;

    always_comb begin
        n_state     = r_state;
        n_have      = r_have;
        n_prev      = r_prev;
        n_we        = r_we;
        n_delta     = r_delta;
        n_prod      = r_prod;
        n_t         = r_t;
        n_x_neg     = r_x_neg;
        n_out       = r_out;
        n_out_valid = r_out_valid && !w_out_xfer;
        w_start     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (r_have) begin
                        n_delta = $signed({i_global_time[TIME_W-1], i_global_time})
                                - $signed({r_prev[TIME_W-1], r_prev});
                    end else begin
                        n_delta = '0;
                        n_we    = '0;
                    end
                    n_prev  = i_global_time;
                    n_have  = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = PROD_W'(r_delta) * PROD_W'($signed(r_freq));
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_we    = w_we_sat;
                n_state = ST_WRAP;
            end
            ST_WRAP: begin
                n_t     = w_t;
                n_x_neg = w_x[T_W-1];
                n_state = ST_DONE;
                if (w_keys_set && w_wrap_mode) begin
                    if (w_span != '0) begin
                        w_start = 1'b1;
                        n_state = ST_DIV;
                    end else begin
                        n_t = w_kst;
                    end
                end
            end
            ST_DIV: begin
                if (w_rem_sts.done) begin
                    n_t     = (r_cycle_mode == MODE_LOOP) ? w_t_loop : w_t_rev;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    if (!r_play_back) begin
                        n_out = w_clamp[TIME_W-1:0];
                    end else if (&w_back[T_W-1:TIME_W-1] || ~|w_back[T_W-1:TIME_W-1]) begin
                        n_out = w_back[TIME_W-1:0];
                    end else begin
                        n_out = w_back[T_W-1] ? TIME_MIN : TIME_MAX;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have      <= 1'b0;
            r_prev      <= '0;
            r_we        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have      <= n_have;
            r_prev      <= n_prev;
            r_we        <= n_we;
            r_out_valid <= n_out_valid;
        end
        r_delta <= n_delta;
        r_prod  <= n_prod;
        r_t     <= n_t;
        r_x_neg <= n_x_neg;
        r_out   <= n_out;
    end

    ats_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_x_mag[REM_W-1:0]),
        .i_divisor  (w_d_mag[REM_W-1:0]),
        .o_sts      (w_rem_sts),
        .o_rem      (w_rem)
    );

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_scaled_time = r_out;

    a_rem_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_sts.busy |-> r_state == ST_DIV)
        else $error("remainder unit busy outside divide state");

    a_div_done_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && w_rem_sts.done) |=> r_state == ST_DONE)
        else $error("divide completion not followed by finish");

    a_accept_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_MUL && r_have))
        else $error("accepted item did not start or record history");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result lost or overwritten");

endmodule

// ===== tb/sv/animation_time_scaler_tb.sv =====
module animation_time_scaler_tb;
    import ats_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI  = 3'd7;
    localparam longint T_HI         = 64'sd2147483647;
    localparam longint T_LO         = -64'sd2147483648;
    localparam int     DRAIN_CYCLES = 48;
    localparam int     LONG_HOLD    = 300;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic [TIME_W-1:0]     i_global_time = '0;
    logic                  i_out_stall   = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [TIME_W-1:0]     o_scaled_time;

    // predictor copy of registers and history
    logic signed [FREQ_W-1:0] m_freq      = '0;
    logic signed [TIME_W-1:0] m_phase     = '0;
    logic signed [TIME_W-1:0] m_key_start = KEY_START_UNSET;
    logic signed [TIME_W-1:0] m_key_stop  = KEY_STOP_UNSET;
    logic [MODE_W-1:0]        m_mode      = MODE_CLAMP;
    logic                     m_backwards = 1'b0;
    logic [TIME_W-1:0]        m_prev_time = '0;
    logic                     m_have_prev = 1'b0;
    longint                   m_elapsed   = 0;

    logic [TIME_W-1:0] scaled_q[$];
    logic [TIME_W-1:0] frame_now = '0;
    int  errors      = 0;
    int  frames_sent = 0;
    int  results_ok  = 0;
    bit  idle_on     = 1'b0;
    int  hold_reqs   = 0;
    int  holds_done  = 0;
    int  hold_left   = 0;
    int  burst_left  = 0;

    animation_time_scaler DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_global_time (i_global_time),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_scaled_time (o_scaled_time),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint clip32(input longint x);
        if (x > T_HI) return T_HI;
        if (x < T_LO) return T_LO;
        return x;
    endfunction

    function automatic logic [TIME_W-1:0] scale_time(input logic [TIME_W-1:0] gt);
        longint now, dlt, t, ks, ke, span, dspan, f;
        now = longint'($signed(gt));
        ks  = longint'(m_key_start);
        ke  = longint'(m_key_stop);
        if (m_have_prev) begin
            dlt = now - longint'($signed(m_prev_time));
        end else begin
            m_elapsed = 0;
            dlt = 0;
        end
        m_elapsed = clip32(m_elapsed + ((dlt * longint'(m_freq)) >>> FRAC_SHIFT));
        t = m_elapsed + longint'(m_phase);
        m_prev_time = gt;
        m_have_prev = 1'b1;
        span = ke - ks;
        if (m_key_stop != KEY_STOP_UNSET && m_key_start != KEY_START_UNSET) begin
            if (m_mode == MODE_LOOP) begin
                if (span != 0) begin
                    t = (t - ks) % span + ks;
                    if (t < ks) t = t + span;
                end else begin
                    t = ks;
                end
            end else if (m_mode == MODE_REVERSE) begin
                if (span != 0) begin
                    dspan = 2 * span;
                    f = (t - ks) % dspan;
                    if (f < 0) f = f + dspan;
                    t = (f > span) ? dspan - f + ks : f + ks;
                end else begin
                    t = ks;
                end
            end
        end
        if (t > ke) t = ke;
        else if (t < ks) t = ks;
        if (m_backwards) t = clip32(ke - (t - ks));
        return t[TIME_W-1:0];
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (scaled_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected scaled_time %h, nothing pending",
                         $time, o_scaled_time);
            end else begin
                if (o_scaled_time !== scaled_q[0]) begin
                    errors++;
                    $display("%0t: scaled_time mismatch, expected %h, got %h",
                             $time, scaled_q[0], o_scaled_time);
                end else begin
                    results_ok++;
                end
                void'(scaled_q.pop_front());
            end
        end
    end

    // output stall: random bursts, plus long holds on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_reqs) begin
            holds_done <= holds_done + 1;
            hold_left <= LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            i_out_stall <= 1'b1;
            burst_left <= burst_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst_left <= $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // block must be idle; upper junk bits must be dropped by the block
    task automatic program_cfg(input logic [FREQ_W-1:0] f, input logic [TIME_W-1:0] ph,
                               input logic [TIME_W-1:0] ks, input logic [TIME_W-1:0] ke,
                               input logic [MODE_W-1:0] md, input logic bk);
        cfg_write(REG_FREQUENCY, {16'($urandom), f});
        cfg_write(REG_PHASE, ph);
        cfg_write(REG_KEY_START, ks);
        cfg_write(REG_KEY_STOP, ke);
        cfg_write(REG_CYCLE_MODE, {30'($urandom), md});
        cfg_write(REG_PLAY_BACKWARDS, {31'($urandom), bk});
        cfg_write(REG_NONE_LO, $urandom);
        cfg_write(REG_NONE_HI, $urandom);
        i_cfg_we    <= 1'b0;
        m_freq      = f;
        m_phase     = ph;
        m_key_start = ks;
        m_key_stop  = ke;
        m_mode      = md;
        m_backwards = bk;
    endtask

    task automatic send_time(input logic [TIME_W-1:0] t);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_global_time <= t;
        do @(posedge i_clk); while (o_in_stall);
        scaled_q.push_back(scale_time(t));
        frame_now = t;
        frames_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] edge_time();
        case ($urandom_range(0, 4))
            0: return TIME_MAX;
            1: return TIME_MIN;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly monotonic frame clock with occasional rewinds, jumps and repeats
    function automatic logic [TIME_W-1:0] next_frame(input logic [TIME_W-1:0] cur);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return cur + 32'($urandom_range(0, 'h30000));
        if (sel < 16) return cur - 32'($urandom_range(0, 'h30000));
        if (sel < 18) return $urandom;
        return cur;
    endfunction

    task automatic rand_config();
        logic [FREQ_W-1:0] f;
        logic [TIME_W-1:0] ph, ks, ke;
        logic [MODE_W-1:0] md;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) f = 16'h8000;
        else if (sel == 1) f = 16'h7FFF;
        else if (sel == 2) f = 16'($urandom);
        else f = 16'($urandom_range(0, 'h800)) - 16'h400;
        if ($urandom_range(0, 7) == 0) ph = edge_time();
        else ph = 32'($urandom_range(0, 'h100000)) - 32'h80000;
        ks = ph + 32'($urandom_range(0, 'h80000)) - 32'h40000;
        ke = ks + 32'($urandom_range(1, 'h60000));
        case ($urandom_range(0, 11))
            0: ks = KEY_START_UNSET;
            1: ke = KEY_STOP_UNSET;
            2: ke = ks;
            3: ke = ks - 32'($urandom_range(1, 'h40000));
            4: begin
                ks = TIME_MIN;
                ke = TIME_MAX;
            end
            5: begin
                ks = $urandom;
                ke = $urandom;
            end
            default: ;
        endcase
        sel = $urandom_range(0, 19);
        if (sel < 7) md = MODE_LOOP;
        else if (sel < 14) md = MODE_REVERSE;
        else if (sel < 17) md = MODE_CLAMP;
        else md = MODE_UNUSED;
        program_cfg(f, ph, ks, ke, md, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_frames(input int n);
        repeat (n) send_time(next_frame(frame_now));
        drain();
    endtask

    // reset values: keys unset, clamp mode; first transfer has zero delta
    task automatic test_reset_defaults();
        send_time(32'h0001_0000);
        send_time(TIME_MAX);
        send_time(TIME_MIN);
        send_time(32'h0000_0000);
        drain();
    endtask

    task automatic test_wrap_modes();
        program_cfg(16'h0100, '0, 32'h0000_0000, 32'h000A_0000, MODE_LOOP, 1'b0);
        send_time(32'h0005_0000);
        send_time(32'h0019_0000);
        send_time(32'h0000_0000);
        send_time(32'hFFFD_0000);
        drain();
        program_cfg(16'h0100, '0, 32'h0000_0000, 32'h000A_0000, MODE_REVERSE, 1'b0);
        send_time(32'h000C_0000);
        send_time(32'h001B_0000);
        send_time(32'hFFF0_0000);
        drain();
    endtask

    task automatic test_degenerate_keys();
        program_cfg(16'h0100, 32'h0001_8000, 32'h0003_0000, 32'h0003_0000, MODE_LOOP, 1'b0);
        send_time(frame_now + 32'h0002_0000);
        drain();
        program_cfg(16'h0100, 32'h0001_8000, 32'h0003_0000, 32'h0003_0000, MODE_REVERSE,
                    1'b0);
        send_time(frame_now + 32'h0002_0000);
        drain();
        program_cfg(16'h0100, '0, 32'h000A_0000, 32'h0002_0000, MODE_LOOP, 1'b0);
        send_time(frame_now + 32'h0004_0000);
        drain();
        program_cfg(16'h0100, '0, KEY_START_UNSET, 32'h000A_0000, MODE_LOOP, 1'b0);
        send_time(frame_now + 32'h0001_0000);
        drain();
        program_cfg(16'h0080, '0, 32'hFFFF_0000, 32'h0004_0000, MODE_UNUSED, 1'b1);
        send_time(frame_now + 32'h0003_0000);
        drain();
    endtask

    task automatic test_extremes();
        program_cfg(16'h7FFF, TIME_MAX, TIME_MIN, TIME_MAX, MODE_CLAMP, 1'b1);
        send_time(TIME_MIN);
        send_time(TIME_MAX);
        send_time(TIME_MIN);
        drain();
        program_cfg(16'h8000, TIME_MIN, TIME_MIN, TIME_MAX, MODE_REVERSE, 1'b1);
        send_time(TIME_MAX);
        send_time(TIME_MIN);
        drain();
    endtask

    task automatic test_random_phases();
        repeat (14) begin
            idle_on = ($urandom_range(0, 4) != 0);
            rand_config();
            send_frames($urandom_range(80, 120));
        end
    endtask

    task automatic test_output_hold();
        idle_on = 1'b0;
        rand_config();
        hold_reqs++;
        send_frames(24);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        repeat (2) begin
            rand_config();
            send_frames(100);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        idle_on = 1'b1;
        test_reset_defaults();
        test_wrap_modes();
        test_degenerate_keys();
        test_extremes();
        test_random_phases();
        test_output_hold();
        test_steady_stream();
        $display("animation_time_scaler_tb: %0d frame times sent, %0d scaled times matched",
                 frames_sent, results_ok);
        $display("covered loop, ping-pong, clamp and spare mode, unset/zero/negative spans, %s",
                 "backward playback, saturation and a long output hold");
        if (errors == 0) begin
            $display("animation_time_scaler_tb: done, clean");
        end else begin
            $display("animation_time_scaler_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #3200000;
        $display("animation_time_scaler_tb: done, errors");
        $finish;
    end

endmodule
